// ----- rtl/lpc_pkg.sv -----
package lpc_pkg;

  // Input item kinds, carried on in_tuser.
  typedef enum logic [1:0] {
    CMD_EDGE_A = 2'd0,
    CMD_EDGE_B = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TARGET_HEIGHT = 3'd0,
    CFG_TOP_HEIGHT    = 3'd1,
    CFG_GAIN_P        = 3'd2,
    CFG_GAIN_D        = 3'd3,
    CFG_GAIN_I        = 3'd4,
    CFG_HOMING_DUTY   = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int HGT_CFG_W  = 12;
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 8;
  localparam int HEIGHT_W   = 17;
  localparam int ERR_W      = 18;
  localparam int REM_W      = 8;

  localparam int COUNTS_PER_UNIT = 200;
  localparam int ERR_MAX         = 131071;
  localparam int ERR_MIN         = -131072;

  localparam logic [HGT_CFG_W-1:0] TARGET_RESET = 12'd17;
  localparam logic [HGT_CFG_W-1:0] TOP_RESET    = 12'd35;
  localparam logic [GAIN_W-1:0]    GAIN_P_RESET = 16'd6528;
  localparam logic [GAIN_W-1:0]    GAIN_D_RESET = 16'd4070;
  localparam logic [GAIN_W-1:0]    GAIN_I_RESET = 16'd2560;
  localparam logic [DUTY_W-1:0]    HOMING_RESET = 8'd80;
  localparam logic [DUTY_W-1:0]    DUTY_RESET   = 8'd100;
  localparam logic [DUTY_W-1:0]    DUTY_MAX     = 8'd255;

  // One-cycle update request for the position counter.
  typedef struct packed {
    logic inc;
    logic dec;
    logic clear;
  } pos_step_t;

endpackage

// ----- rtl/lift_position_pid_controller.sv -----
// Lift position controller: quadrature encoder count, limit-switch homing
// and a PID duty loop over a window of past errors.
// Input channel (in_*): one item per encoder rising edge or control tick,
// kind on in_tuser. Edges only move the count and give no result; every
// tick gives exactly one result item on out_*.
// Configuration (cfg_*): write enable, register index, data; registers take
// the write on the clock edge and must only be changed while the block idle.
// A tick passes the input register, operand stage, product stage and
// output register in turn before it appears on out_tvalid.
// Throughput: one item per cycle while the result side does not stall,
// edges and ticks mixed in any order; the per-tick path is split so that
// the gain multipliers sit in a stage apart from the wide adds and compares.
// Reset (rst_n low, synchronous): count cleared, homing pending, error
// window cleared, held duty 100, registers back to their reset values.
// When the receiver holds out_tready low the result waits in the output
// register; items keep entering until the stages behind it fill and a tick
// is held at the input, then in_tready drops. Nothing is lost or repeated.
module lift_position_pid_controller #(
  parameter int WINDOW_DEPTH = 10,
  parameter int COUNT_WIDTH  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] other_phase_high, [1] limit_released
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] drive_duty, [8] drive_up, [9] homing,
                                  // [26:10] height_now
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int HW    = COUNT_WIDTH - 6;
  localparam int EXT_W = ((HW > 18) ? HW : 18) + 1;
  localparam int EW    = lpc_pkg::ERR_W;
  localparam int SW    = lpc_pkg::ERR_W + $clog2(WINDOW_DEPTH);
  localparam int GW    = lpc_pkg::GAIN_W;
  localparam int DW    = lpc_pkg::DUTY_W;
  localparam int HTW   = lpc_pkg::HEIGHT_W;
  localparam int CW12  = lpc_pkg::HGT_CFG_W;
  localparam int TOT_W = SW + GW + 3;

  localparam logic signed [EXT_W-1:0] E_HI = EXT_W'(lpc_pkg::ERR_MAX);
  localparam logic signed [EXT_W-1:0] E_LO = EXT_W'(lpc_pkg::ERR_MIN);

  // ---------------- configuration registers ----------------
  logic [CW12-1:0] target_r, top_r;
  logic [GW-1:0]   gain_p_r, gain_d_r, gain_i_r;
  logic [DW-1:0]   homing_duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= lpc_pkg::TARGET_RESET;
      top_r         <= lpc_pkg::TOP_RESET;
      gain_p_r      <= lpc_pkg::GAIN_P_RESET;
      gain_d_r      <= lpc_pkg::GAIN_D_RESET;
      gain_i_r      <= lpc_pkg::GAIN_I_RESET;
      homing_duty_r <= lpc_pkg::HOMING_RESET;
    end else if (cfg_we) begin
      unique case (lpc_pkg::cfg_idx_t'(cfg_index))
        lpc_pkg::CFG_TARGET_HEIGHT: target_r      <= cfg_wdata[CW12-1:0];
        lpc_pkg::CFG_TOP_HEIGHT:    top_r         <= cfg_wdata[CW12-1:0];
        lpc_pkg::CFG_GAIN_P:        gain_p_r      <= cfg_wdata[GW-1:0];
        lpc_pkg::CFG_GAIN_D:        gain_d_r      <= cfg_wdata[GW-1:0];
        lpc_pkg::CFG_GAIN_I:        gain_i_r      <= cfg_wdata[GW-1:0];
        lpc_pkg::CFG_HOMING_DUTY:   homing_duty_r <= cfg_wdata[DW-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic out_valid_r, s1_valid_r, s2_valid_r, s0_valid_r;
  logic out_free, s2_free, s1_free, s0_go, s0_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_tready = !s0_valid_r || s0_go;
  assign s0_fire   = s0_valid_r && s0_go;

  // ---------------- stage 0: input register ----------------
  logic [1:0] s0_cmd_r;
  logic       s0_other_r, s0_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s0_cmd_r   <= in_tuser;
      s0_other_r <= in_tdata[0];
      s0_lim_r   <= in_tdata[1];
    end
  end

  logic is_edge, is_tick, edge_dec;

  always_comb begin
    is_edge  = 1'b0;
    is_tick  = 1'b0;
    edge_dec = 1'b0;
    unique case (lpc_pkg::cmd_t'(s0_cmd_r))
      lpc_pkg::CMD_EDGE_A: begin
        is_edge  = 1'b1;
        edge_dec = !s0_other_r;
      end
      lpc_pkg::CMD_EDGE_B: begin
        is_edge  = 1'b1;
        edge_dec = s0_other_r;
      end
      lpc_pkg::CMD_TICK: is_tick = 1'b1;
      default: ;  // unused code: consumed, no effect
    endcase
  end

  // only ticks need room downstream
  assign s0_go = is_tick ? s1_free : 1'b1;

  // homing state
  logic homing_r, homing_nxt, homing_hold, ctrl_step;

  assign homing_hold = homing_r && s0_lim_r;   // still searching for the switch
  assign ctrl_step   = is_tick && !homing_hold;
  assign homing_nxt  = (s0_fire && is_tick && homing_r && !s0_lim_r) ? 1'b0 : homing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      homing_r <= 1'b1;
    end else begin
      homing_r <= homing_nxt;
    end
  end

  // position counter
  lpc_pkg::pos_step_t     pos_step;
  logic signed [HW-1:0]   pos_height;
  logic [lpc_pkg::REM_W-1:0] pos_rem;

  assign pos_step.inc   = s0_fire && is_edge && !edge_dec;
  assign pos_step.dec   = s0_fire && is_edge && edge_dec;
  assign pos_step.clear = s0_fire && is_tick && homing_r && !s0_lim_r;

  lpc_position #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_position (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (pos_step),
    .height (pos_height),
    .rem    (pos_rem)
  );

  // the tick that finds the switch works on a cleared count
  logic signed [HW-1:0]    height_sel;
  logic signed [EXT_W-1:0] e_full;
  logic signed [EW-1:0]    err;
  logic                    up_now;

  assign height_sel = (homing_r && !s0_lim_r) ? '0 : pos_height;
  assign up_now     = ctrl_step &&
                      (EXT_W'(height_sel) != EXT_W'($signed({1'b0, top_r})));
  assign e_full     = EXT_W'($signed({1'b0, target_r})) - EXT_W'(height_sel);

  always_comb begin
    if (e_full > E_HI) begin
      err = EW'(lpc_pkg::ERR_MAX);
    end else if (e_full < E_LO) begin
      err = EW'(lpc_pkg::ERR_MIN);
    end else begin
      err = e_full[EW-1:0];
    end
  end

  logic signed [EW:0]   win_diff;
  logic signed [SW-1:0] win_sum;

  lpc_err_window #(
    .DEPTH(WINDOW_DEPTH)
  ) u_err_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (s0_fire && ctrl_step),
    .err     (err),
    .diff    (win_diff),
    .sum_nxt (win_sum)
  );

  // ---------------- stage 1: PID operands ----------------
  logic                 s1_ctrl_r, s1_up_r;
  logic [HTW-1:0]       s1_height_r;
  logic signed [EW-1:0] s1_err_r;
  logic signed [EW:0]   s1_diff_r;
  logic signed [SW-1:0] s1_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= s0_fire && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && is_tick) begin
      s1_ctrl_r   <= ctrl_step;
      s1_up_r     <= up_now;
      s1_height_r <= HTW'(height_sel);
      s1_err_r    <= err;
      s1_diff_r   <= win_diff;
      s1_sum_r    <= win_sum;
    end
  end

  // ---------------- stage 2: products ----------------
  logic                    s1_move;
  logic                    s2_ctrl_r, s2_up_r;
  logic [HTW-1:0]          s2_height_r;
  logic signed [EW+GW:0]   prod_p;
  logic signed [EW+GW+1:0] prod_d;
  logic signed [SW+GW:0]   prod_i;

  assign s1_move = s1_valid_r && s2_free;

  lpc_pid_mult #(
    .SW(SW)
  ) u_pid_mult (
    .clk      (clk),
    .load     (s1_move),
    .gain_p   (gain_p_r),
    .gain_d   (gain_d_r),
    .gain_i   (gain_i_r),
    .err      (s1_err_r),
    .diff     (s1_diff_r),
    .sum      (s1_sum_r),
    .prod_p_r (prod_p),
    .prod_d_r (prod_d),
    .prod_i_r (prod_i)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_ctrl_r   <= s1_ctrl_r;
      s2_up_r     <= s1_up_r;
      s2_height_r <= s1_height_r;
    end
  end

  // ---------------- stage 3: sum, clamp, output register ----------------
  logic signed [TOT_W-1:0] total;
  logic [DW-1:0]           duty_new;
  logic [DW-1:0]           held_r;
  logic                    s2_move;
  logic [31:0]             out_tdata_r;

  assign total = TOT_W'(prod_p) + TOT_W'(prod_d) + TOT_W'(prod_i);

  // Signed total with 8 fraction bits (Q33.8 at WINDOW_DEPTH 10) truncated to an integer duty, clamped to 0..255
  always_comb begin
    if (total[TOT_W-1]) begin
      duty_new = '0;
    end else if (|total[TOT_W-2:16]) begin
      duty_new = lpc_pkg::DUTY_MAX;
    end else begin
      duty_new = total[15:8];
    end
  end

  assign s2_move = s2_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_r      <= lpc_pkg::DUTY_RESET;
    end else begin
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
      // the step outputs the duty of the previous step, then takes its own
      if (s2_move && s2_ctrl_r) begin
        held_r <= duty_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_tdata_r <= {5'b0, s2_height_r, !s2_ctrl_r, s2_up_r,
                      (s2_ctrl_r ? held_r : homing_duty_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------- checks ----------------
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_rem < lpc_pkg::REM_W'(lpc_pkg::COUNTS_PER_UNIT))
    else $error("position remainder out of range");

  a_homing_once: assert property (@(posedge clk) disable iff (!rst_n)
    !homing_r |=> !homing_r)
    else $error("homing restarted");

  a_homing_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tdata_r[9] |-> !out_tdata_r[8])
    else $error("homing result drives up");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !s2_valid_r |-> in_tready)
    else $error("input stalled with empty result side");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r)
    else $error("operand stage dropped a tick");

endmodule

// ----- rtl/lpc_position.sv -----
// Encoder position kept as quotient and remainder of count / 200, so the
// height is available without a divider.
module lpc_position #(
  parameter int COUNT_WIDTH = 24,
  localparam int HW = COUNT_WIDTH - 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpc_pkg::pos_step_t            step,
  output logic signed [HW-1:0]          height,
  output logic [lpc_pkg::REM_W-1:0]     rem
);

  localparam int QW = COUNT_WIDTH - 7;
  localparam int RW = lpc_pkg::REM_W;
  localparam longint CPU  = lpc_pkg::COUNTS_PER_UNIT;
  localparam longint HALF = longint'(1) << (COUNT_WIDTH - 1);
  // floor division of the count extremes
  localparam longint MIN_Q_L = -((HALF + CPU - 1) / CPU);
  localparam longint MIN_R_L = -HALF - MIN_Q_L * CPU;
  localparam longint MAX_Q_L = (HALF - 1) / CPU;
  localparam longint MAX_R_L = (HALF - 1) % CPU;

  localparam logic signed [QW-1:0] MIN_Q = QW'(MIN_Q_L);
  localparam logic signed [QW-1:0] MAX_Q = QW'(MAX_Q_L);
  localparam logic [RW-1:0] MIN_R  = RW'(MIN_R_L);
  localparam logic [RW-1:0] MAX_R  = RW'(MAX_R_L);
  localparam logic [RW-1:0] LAST_R = RW'(CPU - 1);

  logic signed [QW-1:0] q_r, q_nxt;
  logic [RW-1:0]        r_r, r_nxt;
  logic signed [HW-1:0] q_ext;
  logic                 adj;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    if (step.clear) begin
      q_nxt = '0;
      r_nxt = '0;
    end else if (step.inc) begin
      if (q_r == MAX_Q && r_r == MAX_R) begin
        q_nxt = MIN_Q;
        r_nxt = MIN_R;
      end else if (r_r == LAST_R) begin
        q_nxt = q_r + QW'(1);
        r_nxt = '0;
      end else begin
        r_nxt = r_r + RW'(1);
      end
    end else if (step.dec) begin
      if (q_r == MIN_Q && r_r == MIN_R) begin
        q_nxt = MAX_Q;
        r_nxt = MAX_R;
      end else if (r_r == '0) begin
        q_nxt = q_r - QW'(1);
        r_nxt = LAST_R;
      end else begin
        r_nxt = r_r - RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
      r_r <= '0;
    end else begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  // truncation toward zero: negative counts with a remainder round up
  assign adj    = q_r[QW-1] && (r_r != '0);
  assign q_ext  = HW'(q_r);
  assign height = -(q_ext + HW'(adj));
  assign rem    = r_r;

endmodule

// ----- rtl/lpc_err_window.sv -----
// Shift window of past errors with a running sum.
module lpc_err_window #(
  parameter int DEPTH = 10,
  localparam int EW = lpc_pkg::ERR_W,
  localparam int SW = lpc_pkg::ERR_W + $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  logic signed [EW-1:0] err,
  output logic signed [EW:0]   diff,
  output logic signed [SW-1:0] sum_nxt
);

  logic signed [EW-1:0] win_r [DEPTH];
  logic signed [SW-1:0] sum_r;

  assign diff    = (EW+1)'(err) - (EW+1)'(win_r[0]);
  assign sum_nxt = sum_r + SW'(err) - SW'(win_r[DEPTH-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        win_r[k] <= '0;
      end
      sum_r <= '0;
    end else if (shift) begin
      win_r[0] <= err;
      for (int k = 1; k < DEPTH; k++) begin
        win_r[k] <= win_r[k-1];
      end
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- rtl/lpc_pid_mult.sv -----
// Gain multipliers, one registered product per term.
module lpc_pid_mult #(
  parameter int SW = 22,
  localparam int EW = lpc_pkg::ERR_W,
  localparam int GW = lpc_pkg::GAIN_W
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [GW-1:0]              gain_p,
  input  logic [GW-1:0]              gain_d,
  input  logic [GW-1:0]              gain_i,
  input  logic signed [EW-1:0]       err,
  input  logic signed [EW:0]         diff,
  input  logic signed [SW-1:0]       sum,
  output logic signed [EW+GW:0]      prod_p_r,
  output logic signed [EW+GW+1:0]    prod_d_r,
  output logic signed [SW+GW:0]      prod_i_r
);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_p_r <= (EW+GW+1)'($signed({1'b0, gain_p})) * (EW+GW+1)'(err);
      prod_d_r <= (EW+GW+2)'($signed({1'b0, gain_d})) * (EW+GW+2)'(diff);
      prod_i_r <= (SW+GW+1)'($signed({1'b0, gain_i})) * (SW+GW+1)'(sum);
    end
  end

endmodule
